// File: src/mnh_pkg.sv
// ----------------------------------------------------------------------------
// mnh_pkg
// Shared types and constants of the mesh next-hop route table.
// ----------------------------------------------------------------------------
package mnh_pkg;

    localparam int DEST_SLOTS = 32;
    localparam int WAYS       = 4;
    localparam int SLOT_W     = (DEST_SLOTS > 1) ? $clog2(DEST_SLOTS) : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ID_W       = 32;
    localparam int HOP_W      = 8;
    // one row = WAYS x {in_use, active, next hop, hops}
    localparam int WAYREC_W   = 2 + ID_W + HOP_W;
    localparam int ROW_W      = WAYS * WAYREC_W;

    typedef enum logic [2:0] {
        ACT_UPDATE = 3'd0,
        ACT_ADVERT = 3'd1,
        ACT_HEARD  = 3'd2,
        ACT_QUERY  = 3'd3,
        ACT_UNLINK = 3'd4,
        ACT_LINK   = 3'd5,
        ACT_REMOVE = 3'd6,
        ACT_NONE   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic              in_use;
        logic              active;
        logic [ID_W-1:0]   next_hop;
        logic [HOP_W-1:0]  hops;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

endpackage

// File: src/mnh_ram.sv
// ----------------------------------------------------------------------------
// mnh_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: src/mesh_next_hop_route_table.sv
// ----------------------------------------------------------------------------
// mesh_next_hop_route_table
// Destination slots with WAYS candidate next hops each; rows held in RAM.
// ----------------------------------------------------------------------------
// channel | direction | signals
// command | in        | start, busy, i_action, i_dest_id, i_via_id, i_hop_steps
// result  | out       | o_valid, o_status, o_route_found, o_best_via, o_best_steps
//
// Destination keys sit in flops with valid bits (one compare per slot);
// way rows live in one RAM, one row per slot. Busy after the accepting edge:
// update/advert lookup, read, wait, modify, done; query ends at modify; heard
// runs lookup to modify twice (via_id, then dest_id), then done; unlink/link/
// remove walk every slot (read, wait, write back), then done. Result beat sits
// on the ports in the first idle cycle; one per command, receiver cannot stall.
// No clearing pass: valid bits reset at once; rows are written clean on allocation.
// ----------------------------------------------------------------------------
module mesh_next_hop_route_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_action,
    input  logic [mnh_pkg::ID_W-1:0]  i_dest_id,
    input  logic [mnh_pkg::ID_W-1:0]  i_via_id,
    input  logic [mnh_pkg::HOP_W-1:0] i_hop_steps,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic                      o_route_found,
    output logic [mnh_pkg::ID_W-1:0]  o_best_via,
    output logic [mnh_pkg::HOP_W-1:0] o_best_steps
);
    import mnh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOKUP, S_READ, S_WAIT, S_MODIFY, S_SWEEP_RD, S_SWEEP_WAIT,
        S_SWEEP_WR, S_DONE
    } t_state;

    t_state            r_state;
    t_action           r_act;
    logic [ID_W-1:0]   r_dest, r_via, r_key;
    logic [HOP_W-1:0]  r_steps, r_val;
    logic              r_second;   // heard: second pass on dest_id
    logic              r_full;
    logic [SLOT_W-1:0] r_slot;
    logic              r_fresh;
    logic              r_slot_ok;

    logic [DEST_SLOTS-1:0] r_dvalid;
    logic [ID_W-1:0]       r_dkey [DEST_SLOTS];

    logic              ram_we;
    logic [SLOT_W-1:0] ram_addr;
    t_row              ram_wdata, ram_rdata, row_in;

    mnh_ram #(.WIDTH(ROW_W), .DEPTH(DEST_SLOTS)) u_rows (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // slot search over key flops
    logic              hit, free_any;
    logic [SLOT_W-1:0] hit_idx, free_idx;
    always_comb begin
        hit = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0;
        for (int s = DEST_SLOTS - 1; s >= 0; s--) begin
            if (r_dvalid[s] && r_dkey[s] == r_key) begin
                hit = 1'b1; hit_idx = SLOT_W'(s);
            end
            if (!r_dvalid[s]) begin
                free_any = 1'b1; free_idx = SLOT_W'(s);
            end
        end
    end

    // row modification for store
    t_row              row_st;
    logic              m_found, f_found, x_found;
    logic [WAY_W-1:0]  m_w, f_w, x_w, pick;
    logic [HOP_W:0]    x_val;
    always_comb begin
        row_in  = r_fresh ? t_row'('0) : ram_rdata;
        m_found = 1'b0; m_w = '0; f_found = 1'b0; f_w = '0;
        x_found = 1'b0; x_w = '0; x_val = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (row_in[w].in_use) begin
                if (row_in[w].next_hop == r_via && !m_found) begin
                    m_found = 1'b1; m_w = WAY_W'(w);
                end
                if (!x_found || {1'b0, row_in[w].hops} > x_val) begin
                    x_found = 1'b1; x_w = WAY_W'(w); x_val = {1'b0, row_in[w].hops};
                end
            end else if (!f_found) begin
                f_found = 1'b1; f_w = WAY_W'(w);
            end
        end
        pick   = f_found ? f_w : x_w;
        row_st = row_in;
        if (m_found) begin
            row_st[m_w].hops = r_val;
        end else begin
            row_st[pick].in_use   = 1'b1;
            row_st[pick].active   = 1'b1;
            row_st[pick].next_hop = r_via;
            row_st[pick].hops     = r_val;
        end
    end

    // query selection
    logic              q_found;
    logic [WAY_W-1:0]  q_w;
    always_comb begin
        q_found = 1'b0; q_w = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (ram_rdata[w].in_use && ram_rdata[w].active &&
                (!q_found || ram_rdata[w].hops < ram_rdata[q_w].hops)) begin
                q_found = 1'b1; q_w = WAY_W'(w);
            end
        end
    end

    // sweep row modification
    t_row row_sw;
    logic rm_done;
    always_comb begin
        row_sw  = ram_rdata;
        rm_done = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (ram_rdata[w].in_use && ram_rdata[w].next_hop == r_via) begin
                if (r_act == ACT_REMOVE) begin
                    if (!rm_done) begin
                        row_sw[w] = '0;
                        rm_done   = 1'b1;
                    end
                end else begin
                    row_sw[w].active = (r_act == ACT_LINK);
                end
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_slot;
        ram_wdata = row_st;
        if (r_state == S_MODIFY && r_slot_ok && r_act != ACT_QUERY) begin
            ram_we = 1'b1;
        end else if (r_state == S_SWEEP_WR && r_dvalid[r_slot]) begin
            ram_we    = 1'b1;
            ram_wdata = row_sw;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dvalid <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_act    <= t_action'(i_action);
                        r_dest   <= i_dest_id;
                        r_via    <= i_via_id;
                        r_steps  <= i_hop_steps;
                        r_full   <= 1'b0;
                        r_second <= 1'b0;
                        r_slot   <= '0;
                        case (t_action'(i_action))
                            ACT_UPDATE: begin
                                r_key <= i_dest_id; r_val <= i_hop_steps;
                                r_state <= S_LOOKUP;
                            end
                            ACT_ADVERT: begin
                                r_key <= i_dest_id;
                                r_val <= (i_hop_steps == '1) ? i_hop_steps
                                                             : i_hop_steps + HOP_W'(1);
                                r_state <= S_LOOKUP;
                            end
                            ACT_HEARD: begin
                                r_key <= i_via_id; r_val <= HOP_W'(1);
                                r_state <= S_LOOKUP;
                            end
                            ACT_QUERY: begin
                                r_key <= i_dest_id; r_state <= S_LOOKUP;
                            end
                            ACT_UNLINK, ACT_LINK, ACT_REMOVE: r_state <= S_SWEEP_RD;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_LOOKUP: begin
                    r_fresh <= 1'b0;
                    if (hit) begin
                        r_slot <= hit_idx; r_slot_ok <= 1'b1;
                    end else if (r_act != ACT_QUERY && free_any) begin
                        r_slot <= free_idx; r_slot_ok <= 1'b1; r_fresh <= 1'b1;
                        r_dvalid[free_idx] <= 1'b1;
                        r_dkey[free_idx]   <= r_key;
                    end else begin
                        r_slot_ok <= 1'b0;
                        r_full    <= 1'b1;
                    end
                    r_state <= S_READ;
                end
                S_READ:  r_state <= S_WAIT;   // address presented, data next
                S_WAIT:  r_state <= S_MODIFY;
                S_MODIFY: begin
                    if (r_act == ACT_QUERY) begin
                        o_valid       <= 1'b1;
                        o_status      <= r_slot_ok ? ST_OK : ST_NOTFOUND;
                        o_route_found <= r_slot_ok && q_found;
                        o_best_via    <= (r_slot_ok && q_found) ? ram_rdata[q_w].next_hop
                                                               : '0;
                        o_best_steps  <= (r_slot_ok && q_found) ? ram_rdata[q_w].hops : '0;
                        r_state       <= S_IDLE;
                    end else if (r_act == ACT_HEARD && !r_second) begin
                        r_second <= 1'b1;
                        r_key    <= r_dest;
                        r_val    <= r_steps;
                        r_state  <= S_LOOKUP;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SWEEP_RD:   r_state <= S_SWEEP_WAIT;
                S_SWEEP_WAIT: r_state <= S_SWEEP_WR;
                S_SWEEP_WR: begin
                    if (r_slot == SLOT_W'(DEST_SLOTS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_slot  <= r_slot + SLOT_W'(1);
                        r_state <= S_SWEEP_RD;
                    end
                end
                S_DONE: begin
                    o_valid       <= 1'b1;
                    o_status      <= r_full ? ST_FULL : ST_OK;
                    o_route_found <= 1'b0;
                    o_best_via    <= '0;
                    o_best_steps  <= '0;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
